// ===== design/actio_pkg.sv =====
// ----------------------------------------------------------------------------
// Audio CPU timer and I/O register package
// Shared types, register offsets and reset constants for the sound-CPU
// register window and its timers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package actio_pkg;

	typedef enum logic [2:0] {
		FN_CYCLE      = 3'd0,
		FN_CPU_READ   = 3'd1,
		FN_CPU_WRITE  = 3'd2,
		FN_HOST_WRITE = 3'd3,
		FN_HOST_READ  = 3'd4
	} func_t;

	localparam logic [3:0] REG_TEST     = 4'd0;
	localparam logic [3:0] REG_CONTROL  = 4'd1;
	localparam logic [3:0] REG_DSP_ADDR = 4'd2;
	localparam logic [3:0] REG_DSP_DATA = 4'd3;
	localparam logic [3:0] REG_PORT0    = 4'd4;
	localparam logic [3:0] REG_PORT1    = 4'd5;
	localparam logic [3:0] REG_PORT2    = 4'd6;
	localparam logic [3:0] REG_PORT3    = 4'd7;
	localparam logic [3:0] REG_AUX0     = 4'd8;
	localparam logic [3:0] REG_AUX1     = 4'd9;
	localparam logic [3:0] REG_TARGET0  = 4'd10;
	localparam logic [3:0] REG_TARGET1  = 4'd11;
	localparam logic [3:0] REG_TARGET2  = 4'd12;
	localparam logic [3:0] REG_COUNTER0 = 4'd13;
	localparam logic [3:0] REG_COUNTER1 = 4'd14;
	localparam logic [3:0] REG_COUNTER2 = 4'd15;

	localparam logic [7:0] CONTROL_RESET = 8'hB0;
	localparam logic [7:0] TEST_RESET    = 8'h0A;
	localparam logic [7:0] HOST_PORT0_RESET = 8'hAA;
	localparam logic [7:0] HOST_PORT1_RESET = 8'hBB;
	localparam logic [6:0] DSP_ENDX_ADDR  = 7'h7C;
	localparam logic [6:0] DSP_FLG_ADDR   = 7'h6C;
	localparam logic [7:0] DSP_FLG_RESET  = 8'hE0;
	localparam int         DSP_DEPTH      = 128;
	localparam int         NUM_TIMERS     = 3;
	localparam logic [6:0] FAST_PHASE     = 7'd1;
	localparam logic [3:0] SLOW_PHASE     = 4'd1;

endpackage

// ===== design/audio_cpu_timer_and_io_registers_unit.sv =====
// ----------------------------------------------------------------------------
// Audio CPU timer and I/O register unit
// Register window 0xF0-0xFF of the sound CPU: control, DSP access, host
// ports, scratch bytes and three timers, one transfer per item.
// ----------------------------------------------------------------------------
// Each input transfer on s_* is one machine cycle, CPU read, CPU write, host
// port write or host port read; s_tuser carries the kind. Every item gives
// exactly one output transfer on m_*, holding the read byte (zero for items
// that are not reads) and the boot ROM overlay bit of CONTROL.
// An accepted item sits in the input register until it advances, and its
// result is then registered in the output register, which raises m_tvalid.
// One item is taken per cycle while m_tready stays high.
// The DSP register file is a 128-entry memory read at the current DSP
// address into a register after every update, with per-entry valid bits
// that stand in for its reset contents.
// Reset restores the window registers, the timers and the host ports to their
// power-on values at once. When the receiver stalls, the result register
// holds and the input register fills, after which s_tready drops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module audio_cpu_timer_and_io_registers_unit
	import actio_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // reg_index[3:0], port_index[5:4], write_data[13:6], p_flag[14]
	input  logic [2:0]  s_tuser,  // func[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata   // read_data[7:0], boot_rom_mapped[8]
);

	logic       valid_s1;
	func_t      func_s1;
	logic [3:0] reg_s1;
	logic [1:0] port_s1;
	logic [7:0] data_s1;
	logic       p_s1;
	logic       advance;

	logic [6:0] div_q, div_d;
	logic [7:0] control_q, control_d;
	logic [7:0] test_q, test_d;
	logic [7:0] dsp_addr_q, dsp_addr_d;
	logic [7:0] to_host_q [4];
	logic [7:0] to_host_d [4];
	logic [7:0] from_host_q [4];
	logic [7:0] from_host_d [4];
	logic [7:0] aux_q [2];
	logic [7:0] aux_d [2];
	logic [7:0] target_q [NUM_TIMERS];
	logic [7:0] target_d [NUM_TIMERS];
	logic [7:0] stage_q [NUM_TIMERS];
	logic [7:0] stage_d [NUM_TIMERS];
	logic [3:0] count_q [NUM_TIMERS];
	logic [3:0] count_d [NUM_TIMERS];
	logic [NUM_TIMERS-1:0] tick;

	logic [7:0]           dsp_mem [DSP_DEPTH];
	logic [DSP_DEPTH-1:0] dsp_valid_q;
	logic                 mem_we;
	logic [6:0]           mem_waddr;
	logic [7:0]           mem_wdata;
	logic [6:0]           mem_raddr;
	logic [7:0]           mem_rd_q;
	logic                 mem_rd_valid_q;
	logic                 byp_q;
	logic [7:0]           byp_data_q;
	logic [6:0]           rd_addr_q;
	logic [7:0]           dsp_read;

	logic [7:0] read_d;
	logic       out_valid_q;
	logic [7:0] read_q;
	logic       boot_q;

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			func_s1 <= func_t'(s_tuser);
			reg_s1  <= s_tdata[3:0];
			port_s1 <= s_tdata[5:4];
			data_s1 <= s_tdata[13:6];
			p_s1    <= s_tdata[14];
		end
	end

	always_comb begin
		if (byp_q) begin
			dsp_read = byp_data_q;
		end else if (mem_rd_valid_q) begin
			dsp_read = mem_rd_q;
		end else if (rd_addr_q == DSP_FLG_ADDR) begin
			dsp_read = DSP_FLG_RESET;
		end else begin
			dsp_read = 8'h00;
		end
	end

	always_comb begin
		div_d      = div_q;
		control_d  = control_q;
		test_d     = test_q;
		dsp_addr_d = dsp_addr_q;
		to_host_d   = to_host_q;
		from_host_d = from_host_q;
		aux_d      = aux_q;
		target_d   = target_q;
		stage_d    = stage_q;
		count_d    = count_q;
		read_d     = 8'h00;
		mem_we     = 1'b0;
		mem_waddr  = dsp_addr_q[6:0];
		mem_wdata  = (dsp_addr_q[6:0] == DSP_ENDX_ADDR) ? 8'h00 : data_s1;
		tick       = '0;
		if (advance) begin
			unique case (func_s1)
				FN_CYCLE: begin
					div_d   = div_q + 7'd1;
					tick[0] = (div_d == FAST_PHASE);
					tick[1] = (div_d == FAST_PHASE);
					tick[2] = (div_d[3:0] == SLOW_PHASE);
					for (int i = 0; i < NUM_TIMERS; i++) begin
						if (tick[i] && control_q[i]) begin
							if (stage_q[i] + 8'd1 == target_q[i]) begin
								stage_d[i] = 8'h00;
								count_d[i] = count_q[i] + 4'd1;
							end else begin
								stage_d[i] = stage_q[i] + 8'd1;
							end
						end
					end
				end
				FN_CPU_READ: begin
					unique case (reg_s1)
						REG_DSP_ADDR: read_d = dsp_addr_q;
						REG_DSP_DATA: read_d = dsp_read;
						REG_PORT0, REG_PORT1, REG_PORT2, REG_PORT3:
							read_d = from_host_q[reg_s1[1:0]];
						REG_AUX0, REG_AUX1: read_d = aux_q[reg_s1[0]];
						REG_COUNTER0: begin
							read_d     = {4'h0, count_q[0]};
							count_d[0] = 4'h0;
						end
						REG_COUNTER1: begin
							read_d     = {4'h0, count_q[1]};
							count_d[1] = 4'h0;
						end
						REG_COUNTER2: begin
							read_d     = {4'h0, count_q[2]};
							count_d[2] = 4'h0;
						end
						default: read_d = 8'h00;
					endcase
				end
				FN_CPU_WRITE: begin
					unique case (reg_s1)
						REG_TEST: begin
							if (!p_s1) begin
								test_d = data_s1;
							end
						end
						REG_CONTROL: begin
							control_d = data_s1;
							if (data_s1[4]) begin
								from_host_d[0] = 8'h00;
								from_host_d[1] = 8'h00;
							end
							if (data_s1[5]) begin
								from_host_d[2] = 8'h00;
								from_host_d[3] = 8'h00;
							end
							for (int i = 0; i < NUM_TIMERS; i++) begin
								if (data_s1[i] && !control_q[i]) begin
									stage_d[i] = 8'h00;
									count_d[i] = 4'h0;
								end
							end
						end
						REG_DSP_ADDR: dsp_addr_d = data_s1;
						REG_DSP_DATA: mem_we = !dsp_addr_q[7];
						REG_PORT0, REG_PORT1, REG_PORT2, REG_PORT3:
							to_host_d[reg_s1[1:0]] = data_s1;
						REG_AUX0, REG_AUX1: aux_d[reg_s1[0]] = data_s1;
						REG_TARGET0: target_d[0] = data_s1;
						REG_TARGET1: target_d[1] = data_s1;
						REG_TARGET2: target_d[2] = data_s1;
						default: ;
					endcase
				end
				FN_HOST_WRITE: from_host_d[port_s1] = data_s1;
				FN_HOST_READ:  read_d = to_host_q[port_s1];
				default: ;
			endcase
		end
	end

	assign mem_raddr = dsp_addr_d[6:0];

	always_ff @(posedge clk) begin
		if (mem_we) begin
			dsp_mem[mem_waddr] <= mem_wdata;
		end
		mem_rd_q   <= dsp_mem[mem_raddr];
		byp_data_q <= mem_wdata;
		rd_addr_q  <= mem_raddr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dsp_valid_q    <= '0;
			mem_rd_valid_q <= 1'b0;
			byp_q          <= 1'b0;
		end else begin
			if (mem_we) begin
				dsp_valid_q[mem_waddr] <= 1'b1;
			end
			mem_rd_valid_q <= dsp_valid_q[mem_raddr];
			byp_q          <= mem_we && (mem_waddr == mem_raddr);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_q        <= '0;
			control_q    <= CONTROL_RESET;
			test_q       <= TEST_RESET;
			dsp_addr_q   <= 8'h00;
			to_host_q[0] <= HOST_PORT0_RESET;
			to_host_q[1] <= HOST_PORT1_RESET;
			to_host_q[2] <= 8'h00;
			to_host_q[3] <= 8'h00;
			for (int i = 0; i < 4; i++) begin
				from_host_q[i] <= 8'h00;
			end
			for (int i = 0; i < 2; i++) begin
				aux_q[i] <= 8'h00;
			end
			for (int i = 0; i < NUM_TIMERS; i++) begin
				target_q[i] <= 8'h00;
				stage_q[i]  <= 8'h00;
				count_q[i]  <= 4'hF;
			end
			out_valid_q <= 1'b0;
			boot_q      <= CONTROL_RESET[7];
		end else begin
			div_q       <= div_d;
			control_q   <= control_d;
			test_q      <= test_d;
			dsp_addr_q  <= dsp_addr_d;
			to_host_q   <= to_host_d;
			from_host_q <= from_host_d;
			aux_q       <= aux_d;
			target_q    <= target_d;
			stage_q     <= stage_d;
			count_q     <= count_d;
			if (advance) begin
				out_valid_q <= 1'b1;
				boot_q      <= control_d[7];
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			read_q <= read_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'h00, boot_q, read_q};

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// Testbench for the audio CPU timer and I/O register unit
// Drives machine cycles, CPU reads and writes and host port accesses, with
// random bursts and receiver stalls, through a directed part, a run of
// machine cycles with small timer targets, and a random part. An internal
// model of the register window predicts every result, and each output
// transfer is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
	import actio_pkg::*;

	localparam int CLK_PERIOD   = 10;
	localparam int RANDOM_ITEMS = 400;
	localparam int RUN_CYCLES   = 192;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 10;
	localparam int CTRL_CLR01   = 4;
	localparam int CTRL_CLR23   = 5;
	localparam int CTRL_BOOT    = 7;

	typedef struct packed {
		logic [2:0] fn;
		logic [3:0] reg_index;
		logic [1:0] port_index;
		logic [7:0] write_data;
		logic       p_flag;
	} window_item_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       boot_rom_mapped;
	} window_result_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;
	logic [2:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;

	window_item_t   pending_items[$];
	window_result_t expected_results[$];
	window_item_t   drive_item;
	window_item_t   next_item;
	window_result_t got_result;
	window_result_t want_result;
	logic           item_taken;
	int             burst_left;
	int             gap_left;
	int             stall_mode;
	int             stall_left;
	int             mismatches;
	int             result_count;
	int             cycle_count;

	logic [15:0] div_count;
	logic [7:0]  ctrl_reg;
	logic [7:0]  test_reg;
	logic [7:0]  dsp_addr;
	logic [7:0]  dsp_regs[DSP_DEPTH];
	logic [7:0]  c2h_ports[4];
	logic [7:0]  h2c_ports[4];
	logic [7:0]  aux_regs[2];
	logic [7:0]  tmr_target[NUM_TIMERS];
	logic [7:0]  tmr_stage[NUM_TIMERS];
	logic [3:0]  tmr_out[NUM_TIMERS];

	audio_cpu_timer_and_io_registers_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	function automatic window_item_t mk(logic [2:0] fn, logic [3:0] r, logic [1:0] port,
			logic [7:0] d, logic p);
		window_item_t it;
		it.fn = fn;
		it.reg_index = r;
		it.port_index = port;
		it.write_data = d;
		it.p_flag = p;
		return it;
	endfunction

	task automatic queue_item(window_item_t it);
		pending_items.insert(pending_items.size(), it);
	endtask

	task automatic window_reset();
		div_count = '0;
		ctrl_reg = CONTROL_RESET;
		test_reg = TEST_RESET;
		dsp_addr = '0;
		for (int i = 0; i < DSP_DEPTH; i++)
			dsp_regs[i] = '0;
		dsp_regs[DSP_FLG_ADDR] = DSP_FLG_RESET;
		c2h_ports[0] = HOST_PORT0_RESET;
		c2h_ports[1] = HOST_PORT1_RESET;
		c2h_ports[2] = '0;
		c2h_ports[3] = '0;
		for (int i = 0; i < 4; i++)
			h2c_ports[i] = '0;
		aux_regs[0] = '0;
		aux_regs[1] = '0;
		for (int i = 0; i < NUM_TIMERS; i++) begin
			tmr_target[i] = '0;
			tmr_stage[i] = '0;
			tmr_out[i] = 4'hF;
		end
	endtask

	function automatic void timer_tick(int n);
		if (ctrl_reg[n]) begin
			tmr_stage[n] = tmr_stage[n] + 8'd1;
			if (tmr_stage[n] == tmr_target[n]) begin
				tmr_out[n] = tmr_out[n] + 4'd1;
				tmr_stage[n] = '0;
			end
		end
	endfunction

	function automatic window_result_t window_step(window_item_t it);
		window_result_t res;
		logic [7:0] prev;
		res.read_data = '0;
		case (it.fn)
			FN_CYCLE: begin
				div_count = div_count + 16'd1;
				if (div_count[6:0] == FAST_PHASE) begin
					timer_tick(0);
					timer_tick(1);
				end
				if (div_count[3:0] == SLOW_PHASE)
					timer_tick(2);
			end
			FN_CPU_READ: begin
				case (it.reg_index)
					REG_DSP_ADDR: res.read_data = dsp_addr;
					REG_DSP_DATA: res.read_data = dsp_regs[dsp_addr[6:0]];
					REG_PORT0, REG_PORT1, REG_PORT2, REG_PORT3:
						res.read_data = h2c_ports[it.reg_index[1:0]];
					REG_AUX0, REG_AUX1: res.read_data = aux_regs[it.reg_index[0]];
					REG_COUNTER0, REG_COUNTER1, REG_COUNTER2: begin
						res.read_data = {4'h0, tmr_out[it.reg_index - REG_COUNTER0]};
						tmr_out[it.reg_index - REG_COUNTER0] = '0;
					end
					default: res.read_data = '0;
				endcase
			end
			FN_CPU_WRITE: begin
				case (it.reg_index)
					REG_TEST: if (!it.p_flag) test_reg = it.write_data;
					REG_CONTROL: begin
						prev = ctrl_reg;
						ctrl_reg = it.write_data;
						if (it.write_data[CTRL_CLR01]) begin
							h2c_ports[0] = '0;
							h2c_ports[1] = '0;
						end
						if (it.write_data[CTRL_CLR23]) begin
							h2c_ports[2] = '0;
							h2c_ports[3] = '0;
						end
						for (int i = 0; i < NUM_TIMERS; i++) begin
							if (it.write_data[i] && !prev[i]) begin
								tmr_stage[i] = '0;
								tmr_out[i] = '0;
							end
						end
					end
					REG_DSP_ADDR: dsp_addr = it.write_data;
					REG_DSP_DATA: begin
						if (!dsp_addr[7]) begin
							if (dsp_addr[6:0] == DSP_ENDX_ADDR)
								dsp_regs[DSP_ENDX_ADDR] = '0;
							else
								dsp_regs[dsp_addr[6:0]] = it.write_data;
						end
					end
					REG_PORT0, REG_PORT1, REG_PORT2, REG_PORT3:
						c2h_ports[it.reg_index[1:0]] = it.write_data;
					REG_AUX0, REG_AUX1: aux_regs[it.reg_index[0]] = it.write_data;
					REG_TARGET0, REG_TARGET1, REG_TARGET2:
						tmr_target[it.reg_index - REG_TARGET0] = it.write_data;
					default: ;
				endcase
			end
			FN_HOST_WRITE: h2c_ports[it.port_index] = it.write_data;
			FN_HOST_READ: res.read_data = c2h_ports[it.port_index];
			default: ;
		endcase
		res.boot_rom_mapped = ctrl_reg[CTRL_BOOT];
		return res;
	endfunction

	task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
		if (mismatches < 40)
			$display("mismatch at result %0d: %s got %02h expected %02h",
				result_count, what, got, want);
		mismatches++;
	endtask

	// Input transfers are predicted first, then the output transfer is checked.
	always @(posedge clk) begin
		item_taken = 1'b0;
		if (arst_n && s_tvalid && s_tready) begin
			expected_results.insert(expected_results.size(), window_step(drive_item));
			item_taken = 1'b1;
		end
		if (arst_n && m_tvalid && m_tready) begin
			got_result.read_data = m_tdata[7:0];
			got_result.boot_rom_mapped = m_tdata[8];
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected transfer, read_data", got_result.read_data, 8'h00);
			end else begin
				want_result = expected_results.pop_front();
				if (got_result.read_data !== want_result.read_data)
					report_mismatch("read_data", got_result.read_data, want_result.read_data);
				if (got_result.boot_rom_mapped !== want_result.boot_rom_mapped)
					report_mismatch("boot_rom_mapped", {7'h0, got_result.boot_rom_mapped},
						{7'h0, want_result.boot_rom_mapped});
				if (m_tdata[15:9] !== '0)
					report_mismatch("tdata padding", {1'b0, m_tdata[15:9]}, 8'h00);
			end
			result_count++;
		end
	end

	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || item_taken)) begin
			if (gap_left > 0) begin
				s_tvalid <= 1'b0;
				gap_left--;
			end else if (pending_items.size() > 0) begin
				next_item = pending_items.pop_front();
				drive_item <= next_item;
				s_tvalid <= 1'b1;
				s_tuser <= next_item.fn;
				s_tdata <= {1'b0, next_item.p_flag, next_item.write_data,
					next_item.port_index, next_item.reg_index};
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 32);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left--;
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(8, 64);
		end
		stall_left--;
		case (stall_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= 1'($urandom_range(0, 1));
			2: m_tready <= ($urandom_range(0, 3) == 0);
			default: m_tready <= (stall_left % 5 != 0);
		endcase
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		int sel;
		logic [3:0] r;
		logic [7:0] d;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		drive_item = '0;
		item_taken = 1'b0;
		burst_left = 0;
		gap_left = 0;
		stall_mode = 0;
		stall_left = 0;
		mismatches = 0;
		result_count = 0;
		cycle_count = 0;
		window_reset();
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Power-on values of the counters, the host side ports and the DSP file.
		for (int i = 0; i < NUM_TIMERS; i++)
			queue_item(mk(FN_CPU_READ, REG_COUNTER0 + 4'(i), 2'd0, 8'h00, 1'b0));
		for (int i = 0; i < 4; i++)
			queue_item(mk(FN_HOST_READ, REG_TEST, 2'(i), 8'hFF, 1'b1));
		queue_item(mk(FN_CPU_READ, REG_DSP_DATA, 2'd3, 8'h00, 1'b0));
		queue_item(mk(FN_CPU_WRITE, REG_DSP_ADDR, 2'd0, {1'b0, DSP_FLG_ADDR}, 1'b0));
		queue_item(mk(FN_CPU_READ, REG_DSP_DATA, 2'd0, 8'h00, 1'b0));
		// ENDX clears on any data write.
		queue_item(mk(FN_CPU_WRITE, REG_DSP_ADDR, 2'd0, {1'b0, DSP_ENDX_ADDR}, 1'b0));
		queue_item(mk(FN_CPU_WRITE, REG_DSP_DATA, 2'd0, 8'hFF, 1'b0));
		queue_item(mk(FN_CPU_READ, REG_DSP_DATA, 2'd0, 8'h00, 1'b0));
		// An address above the file ignores writes and reads through the low seven bits.
		queue_item(mk(FN_CPU_WRITE, REG_DSP_ADDR, 2'd0, 8'hEC, 1'b0));
		queue_item(mk(FN_CPU_WRITE, REG_DSP_DATA, 2'd0, 8'h55, 1'b0));
		queue_item(mk(FN_CPU_READ, REG_DSP_DATA, 2'd0, 8'h00, 1'b0));
		queue_item(mk(FN_CPU_READ, REG_DSP_ADDR, 2'd0, 8'h00, 1'b0));
		queue_item(mk(FN_CPU_WRITE, REG_TEST, 2'd0, 8'hFF, 1'b1));
		queue_item(mk(FN_CPU_WRITE, REG_TEST, 2'd0, 8'h00, 1'b0));
		queue_item(mk(FN_CPU_READ, REG_TEST, 2'd0, 8'h00, 1'b0));
		queue_item(mk(FN_HOST_WRITE, REG_TEST, 2'd3, 8'hFF, 1'b0));
		queue_item(mk(FN_CPU_READ, REG_PORT3, 2'd0, 8'h00, 1'b0));
		queue_item(mk(FN_CPU_WRITE, REG_COUNTER0, 2'd0, 8'hFF, 1'b0));
		queue_item(mk(FN_CPU_WRITE, REG_CONTROL, 2'd0, 8'h37, 1'b0));
		queue_item(mk(FN_CPU_READ, REG_PORT3, 2'd0, 8'h00, 1'b0));
		for (int k = 1; k <= 3; k++)
			queue_item(mk(3'(FN_HOST_READ) + 3'(k), 4'hF, 2'd3, 8'hFF, 1'b1));

		while (pending_items.size() != 0 || s_tvalid || expected_results.size() != 0)
			@(posedge clk);

		// Run of machine cycles with small targets; timer 2 ticks on a faster divider phase than timers 0 and 1.
		queue_item(mk(FN_CPU_WRITE, REG_TARGET0, 2'd0, 8'h01, 1'b0));
		queue_item(mk(FN_CPU_WRITE, REG_TARGET1, 2'd0, 8'h00, 1'b0));
		queue_item(mk(FN_CPU_WRITE, REG_TARGET2, 2'd0, 8'h03, 1'b0));
		queue_item(mk(FN_CPU_WRITE, REG_CONTROL, 2'd0, 8'h80, 1'b0));
		queue_item(mk(FN_CPU_WRITE, REG_CONTROL, 2'd0, 8'h87, 1'b0));
		for (int k = 0; k < RUN_CYCLES; k++) begin
			queue_item(mk(FN_CYCLE, 4'($urandom), 2'($urandom), 8'($urandom),
				1'($urandom)));
			if (k % 32 == 31)
				queue_item(mk(FN_CPU_READ, REG_COUNTER0 + 4'((k / 32) % 3),
					2'd0, 8'h00, 1'b0));
		end
		queue_item(mk(FN_CPU_WRITE, REG_TARGET1, 2'd0, 8'h01, 1'b0));
		queue_item(mk(FN_CPU_WRITE, REG_TARGET2, 2'd0, 8'h02, 1'b0));

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			sel = $urandom_range(0, 99);
			if (sel < 45) begin
				queue_item(mk(FN_CYCLE, 4'($urandom), 2'($urandom),
					8'($urandom), 1'($urandom)));
			end else if (sel < 62) begin
				r = $urandom_range(0, 1) ? REG_COUNTER0 + 4'($urandom_range(0, 2))
					: 4'($urandom);
				queue_item(mk(FN_CPU_READ, r, 2'($urandom), 8'($urandom),
					1'($urandom)));
			end else if (sel < 80) begin
				r = 4'($urandom);
				d = 8'($urandom);
				if ((r == REG_TARGET0 || r == REG_TARGET1 || r == REG_TARGET2)
						&& $urandom_range(0, 3) != 0)
					d = 8'($urandom_range(0, 3));
				if (r == REG_CONTROL && $urandom_range(0, 1))
					d = d | 8'h07;
				queue_item(mk(FN_CPU_WRITE, r, 2'($urandom), d, 1'($urandom)));
			end else if (sel < 87) begin
				d = $urandom_range(0, 3) ? 8'($urandom_range(0, 127)) : 8'($urandom);
				queue_item(mk(FN_CPU_WRITE, REG_DSP_ADDR, 2'($urandom), d,
					1'($urandom)));
				if ($urandom_range(0, 1))
					queue_item(mk(FN_CPU_WRITE, REG_DSP_DATA, 2'($urandom),
						8'($urandom), 1'($urandom)));
				queue_item(mk(FN_CPU_READ, REG_DSP_DATA, 2'($urandom),
					8'($urandom), 1'($urandom)));
			end else if (sel < 93) begin
				queue_item(mk(FN_HOST_WRITE, 4'($urandom), 2'($urandom),
					8'($urandom), 1'($urandom)));
			end else if (sel < 99) begin
				queue_item(mk(FN_HOST_READ, 4'($urandom), 2'($urandom),
					8'($urandom), 1'($urandom)));
			end else begin
				queue_item(mk(3'(FN_HOST_READ) + 3'($urandom_range(1, 3)),
					4'($urandom), 2'($urandom), 8'($urandom), 1'($urandom)));
			end
		end

		while (pending_items.size() != 0 || s_tvalid || expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
design/actio_pkg.sv
design/audio_cpu_timer_and_io_registers_unit.sv
dv/testbench.sv
